// ===== rtl/core/tqmr_pkg.sv =====
// shared constants, types and helpers for the tiered query match ranker
`timescale 1ns / 1ps

package tqmr_pkg;

  localparam int MAX_QUERY  = 16;
  localparam int UNIT_SLOTS = 16;
  localparam int UNIT_W     = 16;
  localparam int LEN_W      = 5;
  localparam int TIER_W     = 3;
  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;
  localparam int IDX_W      = 4;

  localparam logic [LEN_W-1:0] QUERY_LIMIT =
    LEN_W'((MAX_QUERY < UNIT_SLOTS) ? MAX_QUERY : UNIT_SLOTS);
  localparam logic [LEN_W-1:0] LEN_MAX    = '1;
  localparam logic [UNIT_W-1:0] SPACE_UNIT = 16'h0020;

  // result tiers, best first
  localparam logic [TIER_W-1:0] TIER_EXACT       = 3'd0;
  localparam logic [TIER_W-1:0] TIER_NAME_PREFIX = 3'd1;
  localparam logic [TIER_W-1:0] TIER_WORD_PREFIX = 3'd2;
  localparam logic [TIER_W-1:0] TIER_SUBSTRING   = 3'd3;
  localparam logic [TIER_W-1:0] TIER_SUBSEQUENCE = 3'd4;
  localparam logic [TIER_W-1:0] TIER_NO_MATCH    = 3'd5;

  // register indexes, one 64-bit slot each
  localparam logic [2:0] REG_QUERY_LEN = 3'd0;
  localparam logic [2:0] REG_UNITS_A   = 3'd1;
  localparam logic [2:0] REG_UNITS_B   = 3'd2;
  localparam logic [2:0] REG_UNITS_C   = 3'd3;
  localparam logic [2:0] REG_UNITS_D   = 3'd4;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic              step;
    logic              clear;
    logic [UNIT_W-1:0] unit;
  } cell_ctrl_t;

  typedef logic [UNIT_SLOTS-1:0][UNIT_W-1:0] query_units_t;

  // clamp the programmed length into 1 .. QUERY_LIMIT
  function automatic logic [LEN_W-1:0] eff_query_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] q;
    q = raw;
    if (q == '0) begin
      q = LEN_W'(1);
    end
    if (q > QUERY_LIMIT) begin
      q = QUERY_LIMIT;
    end
    return q;
  endfunction

endpackage

// ===== rtl/core/tqmr_regs.sv =====
// configuration register file on the apb-style port
`timescale 1ns / 1ps

module tqmr_regs
  import tqmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  query_len,
  output query_units_t      query_units
);

  logic [DATA_W-1:0] units_a;
  logic [DATA_W-1:0] units_b;
  logic [DATA_W-1:0] units_c;
  logic [DATA_W-1:0] units_d;
  logic              wr_en;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      query_len <= LEN_W'(1);
      units_a   <= '0;
      units_b   <= '0;
      units_c   <= '0;
      units_d   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_QUERY_LEN: query_len <= pwdata[LEN_W-1:0];
        REG_UNITS_A:   units_a   <= pwdata;
        REG_UNITS_B:   units_b   <= pwdata;
        REG_UNITS_C:   units_c   <= pwdata;
        REG_UNITS_D:   units_d   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QUERY_LEN: prdata = {{(DATA_W-LEN_W){1'b0}}, query_len};
      REG_UNITS_A:   prdata = units_a;
      REG_UNITS_B:   prdata = units_b;
      REG_UNITS_C:   prdata = units_c;
      REG_UNITS_D:   prdata = units_d;
      default:       prdata = '0;
    endcase
  end

  assign query_units = {units_d, units_c, units_b, units_a};

endmodule

// ===== rtl/core/tqmr_cell.sv =====
// one query position: compare and the substring / word-prefix vector bits
`timescale 1ns / 1ps

module tqmr_cell
  import tqmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [UNIT_W-1:0] query_unit,
  input  logic              active,
  input  logic              sub_in,
  input  logic              word_in,
  output logic              sub_bit,
  output logic              word_bit,
  output logic              sub_next,
  output logic              word_next
);

  logic match;

  assign match     = active & (query_unit == ctrl.unit);
  assign sub_next  = sub_in & match;
  assign word_next = word_in & match;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sub_bit  <= 1'b0;
      word_bit <= 1'b0;
    end else if (ctrl.step) begin
      sub_bit  <= sub_next;
      word_bit <= word_next;
    end
  end

endmodule

// ===== rtl/core/tiered_query_match_ranker.sv =====
// top level: streams name units through a row of query cells and ranks the match
`timescale 1ns / 1ps

// channel   | dir | signals                          | carries
// s_*       | in  | tvalid tready tdata tlast tuser  | one name unit per request
// m_*       | out | tvalid tready tdata              | match tier at end of name
// apb       | in  | psel penable pwrite paddr pwdata | query length and units
//
// one name unit is taken every cycle while s_tready is high; each unit goes through all cells in parallel
// the tier is registered at the edge that takes the last (or empty) unit, valid on m_* next cycle
// the output register holds one tier; input stalls only while it is full and m_tready is low
// synchronous active-high rst clears per-name state, output valid and registers
// to query_len 1 with all units zero

module tiered_query_match_ranker
  import tqmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [15:0] name_unit
  input  logic              s_tlast,   // end_of_name
  input  logic              s_tuser,   // empty_name
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [2:0] match_tier, [7:3] zero
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration
  logic [LEN_W-1:0] query_len;
  query_units_t     query_units;
  logic [LEN_W-1:0] q;
  logic [UNIT_SLOTS-1:0] top_bit;

  // per-name state
  logic [LEN_W-1:0] name_length;
  logic [LEN_W-1:0] name_length_next;
  logic             prefix_alive;
  logic             prefix_alive_next;
  logic             substring_seen;
  logic             substring_seen_next;
  logic             word_prefix_seen;
  logic             word_prefix_seen_next;
  logic [LEN_W-1:0] subsequence_count;
  logic [LEN_W-1:0] subsequence_count_next;
  logic             at_word_start;

  // cell row
  cell_ctrl_t            ctrl;
  logic [UNIT_SLOTS-1:0] sub_vec;
  logic [UNIT_SLOTS-1:0] word_vec;
  logic [UNIT_SLOTS-1:0] sub_vec_next;
  logic [UNIT_SLOTS-1:0] word_vec_next;

  // handshake
  logic             s_accept;
  logic             unit_step;
  logic             name_done;
  logic [TIER_W-1:0] tier;
  logic [TIER_W-1:0] tier_next;
  logic [UNIT_W-1:0] c;

  tqmr_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .query_len   (query_len),
    .query_units (query_units)
  );

  assign q       = eff_query_len(query_len);
  assign top_bit = UNIT_SLOTS'(1) << (q - LEN_W'(1));
  assign c       = s_tdata;

  // a free or draining output slot lets the next unit in
  assign s_tready  = ~m_tvalid | m_tready;
  assign s_accept  = s_tvalid & s_tready;
  assign unit_step = s_accept & ~s_tuser;
  assign name_done = s_accept & (s_tlast | s_tuser);

  assign ctrl.step          = unit_step;
  assign ctrl.clear         = name_done;
  assign ctrl.unit          = c;

  // cell i holds bit i of both shift-and vectors, fed by cell i-1
  for (genvar i = 0; i < UNIT_SLOTS; i++) begin : g_cell
    logic sub_in;
    logic word_in;
    if (i == 0) begin : g_head
      assign sub_in  = 1'b1;
      assign word_in = at_word_start;
    end else begin : g_link
      assign sub_in  = sub_vec[i-1];
      assign word_in = word_vec[i-1];
    end
    tqmr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .query_unit (query_units[i]),
      .active     (LEN_W'(i) < q),
      .sub_in     (sub_in),
      .word_in    (word_in),
      .sub_bit    (sub_vec[i]),
      .word_bit   (word_vec[i]),
      .sub_next   (sub_vec_next[i]),
      .word_next  (word_vec_next[i])
    );
  end

  // prefix, length and greedy subsequence tracking
  always_comb begin
    prefix_alive_next = prefix_alive;
    if ((name_length < q) && (query_units[name_length[IDX_W-1:0]] != c)) begin
      prefix_alive_next = 1'b0;
    end
    subsequence_count_next = subsequence_count;
    if ((subsequence_count < q) && (query_units[subsequence_count[IDX_W-1:0]] == c)) begin
      subsequence_count_next = subsequence_count + LEN_W'(1);
    end
    name_length_next = (name_length < LEN_MAX) ? name_length + LEN_W'(1) : name_length;
    substring_seen_next   = substring_seen | (|(sub_vec_next & top_bit));
    word_prefix_seen_next = word_prefix_seen | (|(word_vec_next & top_bit));
  end

  // best tier from the state after this unit
  always_comb begin
    if (s_tuser) begin
      tier_next = TIER_NO_MATCH;
    end else if (prefix_alive_next && (name_length_next == q)) begin
      tier_next = TIER_EXACT;
    end else if (prefix_alive_next && (name_length_next >= q)) begin
      tier_next = TIER_NAME_PREFIX;
    end else if (word_prefix_seen_next) begin
      tier_next = TIER_WORD_PREFIX;
    end else if (substring_seen_next) begin
      tier_next = TIER_SUBSTRING;
    end else if (subsequence_count_next == q) begin
      tier_next = TIER_SUBSEQUENCE;
    end else begin
      tier_next = TIER_NO_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || name_done) begin
      name_length       <= '0;
      prefix_alive      <= 1'b1;
      substring_seen    <= 1'b0;
      word_prefix_seen  <= 1'b0;
      subsequence_count <= '0;
      at_word_start     <= 1'b1;
    end else if (unit_step) begin
      name_length       <= name_length_next;
      prefix_alive      <= prefix_alive_next;
      substring_seen    <= substring_seen_next;
      word_prefix_seen  <= word_prefix_seen_next;
      subsequence_count <= subsequence_count_next;
      at_word_start     <= (c == SPACE_UNIT);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (name_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (name_done) begin
      tier <= tier_next;
    end
  end

  assign m_tdata = {{(8-TIER_W){1'b0}}, tier};

  // an empty name always ranks as no match
  a_empty_no_match: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tuser) |=> (m_tvalid && (m_tdata[TIER_W-1:0] == TIER_NO_MATCH)))
    else $error("empty name did not give no match");

  // a finished name leaves the tracker in its idle state
  a_name_cleared: assert property (@(posedge clk) disable iff (rst)
    name_done |=> ((name_length == '0) && prefix_alive && at_word_start &&
                   (sub_vec == '0) && (word_vec == '0) && !substring_seen))
    else $error("per-name state not cleared after end of name");

  // a unit that ends no name never produces a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && !name_done) |=> !m_tvalid)
    else $error("result appeared without end of name");

  // the tier code stays within the defined tiers
  a_tier_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[TIER_W-1:0] <= TIER_NO_MATCH))
    else $error("tier code out of range");

endmodule

// ===== verif/tb_tiered_query_match_ranker.sv =====
// self-checking testbench for the tiered query match ranker: directed names, then random phases
`timescale 1ns / 1ps

module tb_tiered_query_match_ranker;
  import tqmr_pkg::*;

  localparam int HOLD_CYCLES = 200;   // long receiver hold-off, fills the block
  localparam int STALL_LIMIT = 3000;  // cycles with nothing accepted before giving up
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 107;

  // one name unit request as it travels on the slave side
  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              end_flag;
    logic              empty_flag;
  } name_req_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata  = '0;   // [15:0] name_unit
  logic              s_tlast  = 1'b0; // end_of_name
  logic              s_tuser  = 1'b0; // empty_name
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;         // [2:0] match_tier, [7:3] zero
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tiered_query_match_ranker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // requests waiting to be offered, and tiers waiting to come out
  name_req_t         unit_backlog[$];
  logic [TIER_W-1:0] tier_expected[$];
  logic [UNIT_W-1:0] name_buf[$];
  int                items_pushed = 0;
  int                mismatches   = 0;
  bit                calm         = 1'b0;  // no idling on either side
  int                hold_req     = 0;     // bumped to ask for a long receiver hold-off
  bit                unit_taken   = 1'b0;

  // register copies as the block should see them
  logic [LEN_W-1:0]  query_len_reg = LEN_W'(1);
  logic [63:0]       query_words[4] = '{64'd0, 64'd0, 64'd0, 64'd0};

  // per-name ranking state
  int                   name_len     = 0;
  bit                   prefix_alive = 1'b1;
  logic [UNIT_SLOTS-1:0] sub_vec     = '0;
  logic [UNIT_SLOTS-1:0] word_vec    = '0;
  bit                   sub_seen     = 1'b0;
  bit                   word_seen    = 1'b0;
  int                   subseq_cnt   = 0;
  bit                   seed_word    = 1'b1;

  // query length in use: zero counts as one, long values clip to the slot count
  function automatic int active_len();
    int n;
    n = int'(query_len_reg);
    if (n == 0) begin
      n = 1;
    end
    if (n > int'(QUERY_LIMIT)) begin
      n = int'(QUERY_LIMIT);
    end
    return n;
  endfunction

  function automatic logic [UNIT_W-1:0] qunit(input int i);
    return query_words[i / 4][(i % 4) * UNIT_W +: UNIT_W];
  endfunction

  task automatic clear_name();
    name_len     = 0;
    prefix_alive = 1'b1;
    sub_vec      = '0;
    word_vec     = '0;
    sub_seen     = 1'b0;
    word_seen    = 1'b0;
    subseq_cnt   = 0;
    seed_word    = 1'b1;
  endtask

  // advance the ranking state by one request; a tier comes out on the last unit or an empty name
  task automatic rank_unit(input name_req_t req, output bit emit,
                           output logic [TIER_W-1:0] tier);
    int n;
    logic [UNIT_SLOTS-1:0] hits;
    logic [UNIT_SLOTS-1:0] top;
    n    = active_len();
    emit = 1'b0;
    tier = TIER_NO_MATCH;
    if (req.empty_flag) begin
      // empty name drops any partial name and ranks as no match
      clear_name();
      emit = 1'b1;
      return;
    end
    hits = '0;
    for (int i = 0; i < n; i++) begin
      if (qunit(i) == req.unit) begin
        hits[i] = 1'b1;
      end
    end
    top = '0;
    top[n-1] = 1'b1;
    if (name_len < n && qunit(name_len) != req.unit) begin
      prefix_alive = 1'b0;
    end
    // shift-and: substring seeds everywhere, word prefix only at word starts
    sub_vec  = {sub_vec[UNIT_SLOTS-2:0], 1'b1} & hits;
    word_vec = {word_vec[UNIT_SLOTS-2:0], seed_word} & hits;
    if ((sub_vec & top) != '0) begin
      sub_seen = 1'b1;
    end
    if ((word_vec & top) != '0) begin
      word_seen = 1'b1;
    end
    seed_word = (req.unit == SPACE_UNIT);
    if (subseq_cnt < n && qunit(subseq_cnt) == req.unit) begin
      subseq_cnt++;
    end
    if (name_len < int'(LEN_MAX)) begin
      name_len++;
    end
    if (req.end_flag) begin
      emit = 1'b1;
      if (prefix_alive && name_len == n) begin
        tier = TIER_EXACT;
      end else if (prefix_alive && name_len >= n) begin
        tier = TIER_NAME_PREFIX;
      end else if (word_seen) begin
        tier = TIER_WORD_PREFIX;
      end else if (sub_seen) begin
        tier = TIER_SUBSTRING;
      end else if (subseq_cnt == n) begin
        tier = TIER_SUBSEQUENCE;
      end else begin
        tier = TIER_NO_MATCH;
      end
      clear_name();
    end
  endtask

  // sender: offers the oldest backlog request, with random gaps while not calm
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || unit_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (!calm && unit_backlog.size() != 0 && $urandom_range(0, 19) == 0) begin
        send_gap = $urandom_range(0, 14);
        s_tvalid <= 1'b0;
      end else if (unit_backlog.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= unit_backlog[0].unit;
        s_tlast  <= unit_backlog[0].end_flag;
        s_tuser  <= unit_backlog[0].empty_flag;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  int hold_seen  = 0;
  int hold_left  = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 14);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor, predictor and watchdog, all on the rising edge
  int idle_cycles = 0;
  always @(posedge clk) begin : sample
    name_req_t         req;
    bit                emit;
    bit                out_taken;
    logic [TIER_W-1:0] tier;
    logic [TIER_W-1:0] want;
    if (rst) begin
      unit_taken  = 1'b0;
      idle_cycles = 0;
    end else begin
      out_taken = m_tvalid && m_tready;
      // check results before predicting, so a stray result cannot match a fresh tier
      if (out_taken) begin
        if (tier_expected.size() == 0) begin
          $error("match_tier: expected none, got %0d", m_tdata[TIER_W-1:0]);
          mismatches++;
        end else begin
          want = tier_expected.pop_front();
          if (m_tdata[TIER_W-1:0] !== want) begin
            $error("match_tier: expected %0d, got %0d", want, m_tdata[TIER_W-1:0]);
            mismatches++;
          end
          if (m_tdata[7:TIER_W] !== '0) begin
            $error("tdata pad: expected 0, got %0h", m_tdata[7:TIER_W]);
            mismatches++;
          end
        end
      end
      unit_taken = s_tvalid && s_tready;
      if (unit_taken) begin
        req = unit_backlog.pop_front();
        rank_unit(req, emit, tier);
        if (emit) begin
          tier_expected = {tier_expected, tier};
        end
      end
      if (unit_taken || out_taken ||
          (unit_backlog.size() == 0 && tier_expected.size() == 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // register write: setup cycle, then access cycle; pready is sampled on the edge
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 3'b000});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_QUERY_LEN) begin
      query_len_reg = val[LEN_W-1:0];
    end else begin
      query_words[idx - REG_UNITS_A] = val;
    end
  endtask

  // wait until the backlog is empty and every tier is back
  task automatic drain();
    while (unit_backlog.size() != 0 || tier_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic push_req(input logic [UNIT_W-1:0] unit, input bit end_flag,
                          input bit empty_flag);
    name_req_t req;
    req.unit       = unit;
    req.end_flag   = end_flag;
    req.empty_flag = empty_flag;
    unit_backlog = {unit_backlog, req};
    items_pushed++;
  endtask

  // queue the buffered name; without close it stays open for a later unit
  task automatic flush_name(input bit close);
    for (int i = 0; i < name_buf.size(); i++) begin
      push_req(name_buf[i], close && (i == name_buf.size() - 1), 1'b0);
    end
    name_buf.delete();
  endtask

  function automatic logic [UNIT_W-1:0] pick_unit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return qunit($urandom_range(0, active_len() - 1));
    end else if (r < 6) begin
      return SPACE_UNIT;
    end else if (r < 8) begin
      return UNIT_W'($urandom_range(16'h0061, 16'h0064));
    end
    return UNIT_W'($urandom);
  endfunction

  function automatic logic [UNIT_W-1:0] query_unit_pick();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return UNIT_W'($urandom_range(16'h0061, 16'h0068));
    end else if (r < 7) begin
      return SPACE_UNIT;
    end
    return UNIT_W'($urandom);
  endfunction

  task automatic copy_query(input int n);
    for (int i = 0; i < n; i++) begin
      name_buf = {name_buf, qunit(i)};
    end
  endtask

  // one random name, mostly shaped around the query so every tier shows up
  task automatic queue_random_name();
    int n;
    int kind;
    int k;
    n    = active_len();
    kind = $urandom_range(0, 19);
    name_buf.delete();
    case (kind)
      0: begin
        push_req(UNIT_W'($urandom), 1'($urandom), 1'b1);
      end
      1: begin
        // partial name cut short by an empty name
        repeat ($urandom_range(1, 4)) name_buf = {name_buf, pick_unit()};
        flush_name(1'b0);
        push_req(UNIT_W'($urandom), 1'($urandom), 1'b1);
      end
      2, 3: begin
        copy_query(n);
      end
      4, 5: begin
        copy_query(n);
        repeat ($urandom_range(1, 5)) name_buf = {name_buf, pick_unit()};
      end
      6, 7, 8: begin
        repeat ($urandom_range(1, 4)) name_buf = {name_buf, pick_unit()};
        name_buf = {name_buf, SPACE_UNIT};
        copy_query(n);
        repeat ($urandom_range(0, 3)) name_buf = {name_buf, pick_unit()};
      end
      9, 10: begin
        repeat ($urandom_range(1, 4)) name_buf = {name_buf, pick_unit()};
        copy_query(n);
        repeat ($urandom_range(0, 3)) name_buf = {name_buf, pick_unit()};
      end
      11, 12: begin
        for (int i = 0; i < n; i++) begin
          repeat ($urandom_range(0, 2)) name_buf = {name_buf, pick_unit()};
          name_buf = {name_buf, qunit(i)};
        end
      end
      13, 14: begin
        copy_query(n);
        k = $urandom_range(0, n - 1);
        name_buf[k] = pick_unit();
        if ($urandom_range(0, 1) == 1) begin
          name_buf = {name_buf, pick_unit()};
        end
      end
      15, 16: begin
        repeat ($urandom_range(1, 12)) name_buf = {name_buf, pick_unit()};
      end
      17: begin
        repeat ($urandom_range(1, 8)) name_buf = {name_buf, UNIT_W'($urandom)};
      end
      18: begin
        // long name, runs the length counter into saturation
        k = $urandom_range(32, 40);
        if ($urandom_range(0, 1) == 1) begin
          copy_query(n);
        end
        while (name_buf.size() < k) begin
          name_buf = {name_buf, pick_unit()};
        end
      end
      default: begin
        name_buf = {name_buf, pick_unit()};
      end
    endcase
    if (name_buf.size() != 0) begin
      flush_name(1'b1);
    end
  endtask

  initial begin : stimulus
    int                len_pick;
    int                target;
    logic [63:0]       word;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: query "ab", one name per tier plus the edge cases
    reg_write(REG_QUERY_LEN, 64'd2);
    reg_write(REG_UNITS_A, 64'h0000_0000_0062_0061);
    push_req(16'hFFFF, 1'b0, 1'b1);                       // empty name
    name_buf = {16'h0061, 16'h0062};                      // exact
    flush_name(1'b1);
    name_buf = {16'h0061, 16'h0062, 16'h0063};            // name prefix
    flush_name(1'b1);
    name_buf = {SPACE_UNIT, 16'h0061, 16'h0062};          // word prefix after a space
    flush_name(1'b1);
    name_buf = {16'h0078, 16'h0061, 16'h0062};            // substring
    flush_name(1'b1);
    name_buf = {16'h0061, 16'h0078, 16'h0062};            // subsequence
    flush_name(1'b1);
    name_buf = {16'h0000, 16'hFFFF};                      // extreme units, no match
    flush_name(1'b1);
    name_buf = {16'h0061};                                // partial name dropped by empty
    flush_name(1'b0);
    push_req(16'h0000, 1'b1, 1'b1);
    // query changes in the middle of a name, gathered state is kept
    name_buf = {16'h0061};
    flush_name(1'b0);
    drain();
    reg_write(REG_UNITS_A, 64'h0000_0000_0063_0061);
    name_buf = {16'h0063};
    flush_name(1'b1);

    // random phases, each with its own query; the extremes come first
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0:       len_pick = 1;
        1:       len_pick = 16;
        2:       len_pick = 0;   // read as one
        3:       len_pick = 31;  // clipped to the slot count
        4:       len_pick = 17;
        default: len_pick = $urandom_range(1, 16);
      endcase
      word = {$urandom, $urandom};
      word[LEN_W-1:0] = LEN_W'(len_pick);
      reg_write(REG_QUERY_LEN, word);
      for (int w = 0; w < 4; w++) begin
        for (int k = 0; k < 4; k++) begin
          if (ph == 5) begin
            word[k*UNIT_W +: UNIT_W] = 16'hFFFF;
          end else if (ph == 6) begin
            word[k*UNIT_W +: UNIT_W] = 16'h0000;
          end else begin
            word[k*UNIT_W +: UNIT_W] = query_unit_pick();
          end
        end
        reg_write(REG_UNITS_A + 3'(w), word);
      end
      if (ph == PHASES - 1) begin
        calm = 1'b1;
      end
      if (ph == 2) begin
        // receiver holds off while the sender keeps offering
        hold_req++;
      end
      target = items_pushed + PHASE_ITEMS;
      while (items_pushed < target) begin
        queue_random_name();
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
